// ===== hw/rtl/bti_pkg.sv =====
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants of the bitmap tag intersection block.
// ----------------------------------------------------------------------------
package bti_pkg;

   // Bits per bitmap word and the bit-within-word field of a post ID.
   localparam int WORD_BITS   = 64;
   localparam int BIT_SEL_W   = 6;
   localparam int POST_ID_W   = 20;
   localparam int WORD_IDX_W  = 14;
   localparam int CFG_W       = 15;
   localparam logic [CFG_W-1:0] CFG_RESET = 15'd16384;

   typedef enum logic [2:0] {
      CMD_CLEAR      = 3'd0,
      CMD_FIRST_ID   = 3'd1,
      CMD_FIRST_WORD = 3'd2,
      CMD_NEXT_ID    = 3'd3,
      CMD_NEXT_WORD  = 3'd4,
      CMD_END_TAG    = 3'd5,
      CMD_PROBE_ID   = 3'd6,
      CMD_PROBE_WORD = 3'd7
   } bti_cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the incoming transaction
      logic sweep_start;  // begin a clear or end-of-tag pass
      logic item_read;    // read both stores at the item's word
      logic item_exec;    // write back or load the response
   } bti_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      bti_cmd_type cmd;         // latched command
      logic        sweep_busy;  // a pass is still running
      logic        rsp_full;    // response register holds an untaken result
   } bti_stat_type;

endpackage

// ===== hw/rtl/bti_ctrl.sv =====
// ----------------------------------------------------------------------------
// bti_ctrl
// Controller state machine: sequences read, execute and sweep phases.
// ----------------------------------------------------------------------------
module bti_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [2:0]            req_tuser,
   output logic                  req_tready,
   input  bti_pkg::bti_stat_type stat,
   output bti_pkg::bti_ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_sweep_cmd;
   logic      is_probe;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign is_sweep_cmd = req_tuser inside {bti_pkg::CMD_CLEAR, bti_pkg::CMD_END_TAG};
   assign is_probe     = stat.cmd inside {bti_pkg::CMD_PROBE_ID, bti_pkg::CMD_PROBE_WORD};

   always_comb begin
      state_in         = state_ff;
      ctrl.capture     = 1'b0;
      ctrl.sweep_start = 1'b0;
      ctrl.item_read   = 1'b0;
      ctrl.item_exec   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.capture = 1'b1;
               if (is_sweep_cmd) begin
                  ctrl.sweep_start = 1'b1;
                  state_in         = ST_SWEEP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ctrl.item_read = 1'b1;
            state_in       = ST_EXEC;
         end
         ST_EXEC: begin
            // A probe waits here until the response register can take it.
            if (!(is_probe && stat.rsp_full)) begin
               ctrl.item_exec = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (!stat.sweep_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The datapath starts its post-reset clearing pass on its own.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/bti_dpath.sv =====
// ----------------------------------------------------------------------------
// bti_dpath
// Datapath: result and scratch stores, sweep counter, response register.
// ----------------------------------------------------------------------------
module bti_dpath #(
   parameter int WORD_COUNT = 16384
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bti_pkg::bti_ctrl_type ctrl,
   output bti_pkg::bti_stat_type stat,
   input  logic [2:0]            req_cmd,
   input  logic [19:0]           req_post_id,
   input  logic [13:0]           req_word_index,
   input  logic [63:0]           req_mask_word,
   input  logic                  csr_tvalid,
   input  logic [14:0]           csr_value,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [19:0]           rsp_post_id,
   output logic                  rsp_hit,
   output logic [13:0]           rsp_word_index,
   output logic [63:0]           rsp_word,
   output logic                  rsp_is_word
);

   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CW = (AW + 1 > bti_pkg::CFG_W) ? AW + 1 : bti_pkg::CFG_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

   logic [63:0] result_mem  [WORD_COUNT];
   logic [63:0] scratch_mem [WORD_COUNT];

   logic [14:0]          wiu_ff;
   logic [CW-1:0]        used;

   bti_pkg::bti_cmd_type cmd_ff;
   logic [19:0]          pid_ff;
   logic [13:0]          widx_ff;
   logic [63:0]          mword_ff;

   logic                 sweep_ff, clear_ff, wb_ff;
   logic [AW-1:0]        cnt_ff, wb_addr_ff;

   logic [63:0]          rd_res_ff, rd_scr_ff;
   logic [CW-1:0]        item_addr;
   logic                 item_ok, wb_ok;
   logic [63:0]          bit_sel;
   logic                 rd_en;

   logic                 rsp_valid_ff;
   logic [19:0]          rsp_pid_ff;
   logic                 rsp_hit_ff;
   logic [13:0]          rsp_widx_ff;
   logic [63:0]          rsp_word_ff;
   logic                 rsp_is_word_ff;

   logic                 res_we, scr_we;
   logic [AW-1:0]        res_waddr, scr_waddr, rd_addr;
   logic [63:0]          res_wdata, scr_wdata;

   assign used = (CW'(wiu_ff) > CW'(WORD_COUNT)) ? CW'(WORD_COUNT) : CW'(wiu_ff);

   // Id commands address word post_id / 64; word commands use word_index.
   assign item_addr = (cmd_ff inside {bti_pkg::CMD_FIRST_ID, bti_pkg::CMD_NEXT_ID,
                                      bti_pkg::CMD_PROBE_ID})
                      ? CW'(pid_ff[19:bti_pkg::BIT_SEL_W]) : CW'(widx_ff);
   assign item_ok   = item_addr < used;
   assign wb_ok     = CW'(wb_addr_ff) < used;
   assign bit_sel   = 64'd1 << pid_ff[bti_pkg::BIT_SEL_W-1:0];
   assign rd_addr   = sweep_ff ? cnt_ff : item_addr[AW-1:0];
   assign rd_en     = sweep_ff || ctrl.item_read;

   always_comb begin
      res_we    = 1'b0;
      res_waddr = cnt_ff;
      res_wdata = '0;
      scr_we    = 1'b0;
      scr_waddr = cnt_ff;
      scr_wdata = '0;
      if (sweep_ff) begin
         scr_we = 1'b1;
         res_we = clear_ff;
      end else if (ctrl.item_exec && item_ok) begin
         case (cmd_ff)
            bti_pkg::CMD_FIRST_ID: begin
               res_we    = 1'b1;
               res_wdata = rd_res_ff | bit_sel;
            end
            bti_pkg::CMD_FIRST_WORD: begin
               res_we    = 1'b1;
               res_wdata = mword_ff;
            end
            bti_pkg::CMD_NEXT_ID: begin
               scr_we    = 1'b1;
               scr_wdata = rd_scr_ff | bit_sel;
            end
            bti_pkg::CMD_NEXT_WORD: begin
               scr_we    = 1'b1;
               scr_wdata = mword_ff;
            end
            default: begin
            end
         endcase
         res_waddr = item_addr[AW-1:0];
         scr_waddr = item_addr[AW-1:0];
      end
      // End-of-tag write-back lands in the cycle after the read of its word.
      if (wb_ff && wb_ok) begin
         res_we    = 1'b1;
         res_waddr = wb_addr_ff;
         res_wdata = rd_res_ff & rd_scr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         result_mem[res_waddr] <= res_wdata;
      end
      if (rd_en) begin
         rd_res_ff <= result_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scratch_mem[scr_waddr] <= scr_wdata;
      end
      if (rd_en) begin
         rd_scr_ff <= scratch_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= bti_pkg::bti_cmd_type'(req_cmd);
         pid_ff   <= req_post_id;
         widx_ff  <= req_word_index;
         mword_ff <= req_mask_word;
      end
      wb_addr_ff <= cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff   <= bti_pkg::CFG_RESET;
         sweep_ff <= 1'b1;
         clear_ff <= 1'b1;
         cnt_ff   <= '0;
         wb_ff    <= 1'b0;
      end else begin
         if (csr_tvalid) begin
            wiu_ff <= csr_value;
         end
         wb_ff <= sweep_ff && !clear_ff;
         if (ctrl.sweep_start) begin
            sweep_ff <= 1'b1;
            clear_ff <= (req_cmd == bti_pkg::CMD_CLEAR);
            cnt_ff   <= '0;
         end else if (sweep_ff) begin
            cnt_ff <= cnt_ff + AW'(1);
            if (cnt_ff == LAST_ADDR) begin
               sweep_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.item_exec &&
                   (cmd_ff inside {bti_pkg::CMD_PROBE_ID, bti_pkg::CMD_PROBE_WORD})) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.item_exec) begin
         if (cmd_ff == bti_pkg::CMD_PROBE_ID) begin
            rsp_pid_ff     <= pid_ff;
            rsp_hit_ff     <= item_ok && ((rd_res_ff & bit_sel) != 64'd0);
            rsp_widx_ff    <= '0;
            rsp_word_ff    <= '0;
            rsp_is_word_ff <= 1'b0;
         end else if (cmd_ff == bti_pkg::CMD_PROBE_WORD) begin
            rsp_pid_ff     <= '0;
            rsp_hit_ff     <= 1'b0;
            rsp_widx_ff    <= widx_ff;
            rsp_word_ff    <= item_ok ? (rd_res_ff & mword_ff) : 64'd0;
            rsp_is_word_ff <= 1'b1;
         end
      end
   end

   assign stat.cmd        = cmd_ff;
   assign stat.sweep_busy = sweep_ff || wb_ff;
   assign stat.rsp_full   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_post_id    = rsp_pid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_word_index = rsp_widx_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_is_word    = rsp_is_word_ff;

endmodule

// ===== hw/rtl/bitmap_tag_intersection.sv =====
// ----------------------------------------------------------------------------
// bitmap_tag_intersection
// Intersects the post sets of several tags in a result bitmap.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tuser=cmd, tdata=id/index/mask
//   rsp      out        rsp_tvalid/rsp_tready  tuser=is_word, tdata=probe result
//   csr      in         csr_tvalid/csr_tready  tdata=words_in_use
//
// An id or word transaction passes through accept, store read and execute.
// A clear or an end-of-tag is paced by the sweep counter walking every word and,
// for end-of-tag, one trailing write-back. After reset a clearing pass holds
// req_tready low; configuration writes are taken at any time.
// A probe stalls in its execute cycle only while an earlier result is untaken.
//
module bitmap_tag_intersection #(
   parameter int WORD_COUNT = 16384
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // post_id, word_index, mask_word, zero pad
   input  logic [2:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // out_post_id, hit, out_word_index, out_word, pad
   output logic [0:0]   rsp_tuser,   // is_word
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [15:0]  csr_tdata    // words_in_use, zero pad
);

   bti_pkg::bti_ctrl_type ctrl;
   bti_pkg::bti_stat_type stat;

   logic [19:0] rsp_post_id;
   logic        rsp_hit;
   logic [13:0] rsp_word_index;
   logic [63:0] rsp_word;
   logic        rsp_is_word;

   // The configuration register accepts a write in every cycle.
   assign csr_tready = 1'b1;

   bti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   bti_dpath #(
      .WORD_COUNT (WORD_COUNT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_cmd        (req_tuser),
      .req_post_id    (req_tdata[19:0]),
      .req_word_index (req_tdata[33:20]),
      .req_mask_word  (req_tdata[97:34]),
      .csr_tvalid     (csr_tvalid),
      .csr_value      (csr_tdata[14:0]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_post_id    (rsp_post_id),
      .rsp_hit        (rsp_hit),
      .rsp_word_index (rsp_word_index),
      .rsp_word       (rsp_word),
      .rsp_is_word    (rsp_is_word)
   );

   // Result fields are packed from the lowest bit up.
   assign rsp_tdata = {5'd0, rsp_word, rsp_word_index, rsp_hit, rsp_post_id};
   assign rsp_tuser = rsp_is_word;

endmodule

// ===== tb/tb_bitmap_tag_intersection.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_tag_intersection
// Self-checking testbench for the bitmap tag intersection block.
// ----------------------------------------------------------------------------
// Queries are built as the software would issue them: a clear, a first tag
// loaded as post IDs or bitmap words, zero to two later tags each closed by an
// end-of-tag command, and a run of ID and word probes. A scoreboard keeps its
// own copy of both bitmaps and of the words-in-use register, predicts every
// probe response and compares it field by field with what the block returns.
// Sender gaps and receiver stalls change from query to query, and one query
// holds the response side off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_bitmap_tag_intersection;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NWORDS = 16384;
   // A clear or end-of-tag pass walks every word plus a little overhead.
   localparam int SWEEP_CYCLES = NWORDS + 64;

   typedef struct {
      logic [19:0] post_id;
      logic        hit;
      logic [13:0] word_index;
      logic [63:0] word;
      logic        is_word;
   } probe_rsp_type;

   // Scoreboard: a private copy of the block's state plus the queue of
   // probe responses that are still owed.
   class intersect_scoreboard;
      logic [63:0]   result_bm [NWORDS];
      logic [63:0]   scratch_bm [NWORDS];
      logic [14:0]   words_cfg;
      probe_rsp_type owed [$];
      int            errors;

      function void reset_state();
         foreach (result_bm[i]) begin
            result_bm[i] = '0;
            scratch_bm[i] = '0;
         end
         words_cfg = bti_pkg::CFG_RESET;
         owed.delete();
         errors = 0;
      endfunction

      function int used_words();
         return (words_cfg > NWORDS) ? NWORDS : int'(words_cfg);
      endfunction

      // Applies one accepted request to the private state and queues the
      // response that a probe is bound to produce.
      function void note_request(bti_pkg::bti_cmd_type cmd, logic [19:0] pid,
                                 logic [13:0] widx, logic [63:0] mask);
         int            used;
         int            w;
         logic [63:0]   bit_sel;
         probe_rsp_type r;
         used = used_words();
         w = int'(pid[19:6]);
         bit_sel = 64'd1 << pid[5:0];
         case (cmd)
            bti_pkg::CMD_CLEAR: begin
               foreach (result_bm[i]) begin
                  result_bm[i] = '0;
                  scratch_bm[i] = '0;
               end
            end
            bti_pkg::CMD_FIRST_ID:   if (w < used) result_bm[w] |= bit_sel;
            bti_pkg::CMD_FIRST_WORD: if (widx < used) result_bm[widx] = mask;
            bti_pkg::CMD_NEXT_ID:    if (w < used) scratch_bm[w] |= bit_sel;
            bti_pkg::CMD_NEXT_WORD:  if (widx < used) scratch_bm[widx] = mask;
            bti_pkg::CMD_END_TAG: begin
               // A zero scratch word wipes the matching result word.
               for (int i = 0; i < used; i++) result_bm[i] &= scratch_bm[i];
               foreach (scratch_bm[i]) scratch_bm[i] = '0;
            end
            bti_pkg::CMD_PROBE_ID: begin
               r.post_id = pid;
               r.hit = (w < used) && ((result_bm[w] & bit_sel) != 0);
               r.word_index = '0;
               r.word = '0;
               r.is_word = 1'b0;
               owed.insert(owed.size(), r);
            end
            default: begin
               r.post_id = '0;
               r.hit = 1'b0;
               r.word_index = widx;
               r.word = (widx < used) ? (result_bm[widx] & mask) : 64'd0;
               r.is_word = 1'b1;
               owed.insert(owed.size(), r);
            end
         endcase
      endfunction

      function void check_response(logic [103:0] data, logic user);
         probe_rsp_type e;
         if (owed.size() == 0) begin
            $error("unexpected response transaction: tdata %h", data);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (data[19:0] !== e.post_id) begin
            $error("out_post_id: expected %h, got %h", e.post_id, data[19:0]);
            errors++;
         end
         if (data[20] !== e.hit) begin
            $error("hit: expected %b, got %b", e.hit, data[20]);
            errors++;
         end
         if (data[34:21] !== e.word_index) begin
            $error("out_word_index: expected %h, got %h", e.word_index, data[34:21]);
            errors++;
         end
         if (data[98:35] !== e.word) begin
            $error("out_word: expected %h, got %h", e.word, data[98:35]);
            errors++;
         end
         if (user !== e.is_word) begin
            $error("is_word: expected %b, got %b", e.is_word, user);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_tvalid;
   logic         csr_tready;
   logic [15:0]  csr_tdata;

   intersect_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  long_hold;
   int  hold_count;

   bitmap_tag_intersection DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit, well beyond the slowest legal run (about sixty full sweeps).
   initial begin
      #(4_000_000 * 20ns);
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off counted here so the
   // block's response register fills and the request side backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_count <= 0;
      end else if (long_hold) begin
         rsp_tready <= 1'b0;
         if (hold_count == 400) begin
            long_hold = 1'b0;
            hold_count <= 0;
         end else begin
            hold_count <= hold_count + 1;
         end
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Handshakes are sampled at the falling edge, where every signal is settled;
   // a response seen there is taken at the next rising edge.
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser[0]);
      end
   end

   // Sends one request transaction and updates the prediction when it is taken.
   task automatic send_req(bti_pkg::bti_cmd_type cmd, logic [19:0] pid,
                           logic [13:0] widx, logic [63:0] mask);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, mask, widx, pid};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      sb.note_request(cmd, pid, widx, mask);
   endtask

   task automatic go_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes only happen with nothing owed and any sweep finished.
   task automatic write_words_in_use(logic [14:0] value);
      bit taken;
      go_idle();
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SWEEP_CYCLES) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {1'b0, value};
      do begin
         @(negedge clock);
         taken = csr_tready;
         @(posedge clock);
      end while (!taken);
      csr_tvalid <= 1'b0;
      sb.words_cfg = value;
   endtask

   // Random post ID, mostly inside a narrow window near the words in use so
   // tags overlap; sometimes anywhere in the full 20-bit range.
   function automatic logic [19:0] pick_id(int lim);
      if ($urandom_range(7) == 0) return 20'($urandom);
      return {14'($urandom_range(lim - 1)), 6'($urandom)};
   endfunction

   function automatic logic [13:0] pick_index(int lim);
      if ($urandom_range(7) == 0) return 14'($urandom);
      return 14'($urandom_range(lim - 1));
   endfunction

   function automatic logic [63:0] pick_mask();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // One query: clear, first tag, later tags, probes. The ID/word window is
   // kept narrow so intersections stay non-empty often enough to give hits.
   task automatic run_query(int q);
      int used;
      int lim;
      int n_next;
      bit as_ids;
      used = sb.used_words();
      lim = (used + 2 > 24) ? 24 : used + 2;
      send_req(bti_pkg::CMD_CLEAR, 20'($urandom), 14'($urandom), pick_mask());
      as_ids = 1'($urandom_range(1));
      repeat ($urandom_range(10, 18)) begin
         if (as_ids) send_req(bti_pkg::CMD_FIRST_ID, pick_id(lim), 14'($urandom),
                              pick_mask());
         else        send_req(bti_pkg::CMD_FIRST_WORD, 20'($urandom), pick_index(lim),
                              pick_mask());
      end
      n_next = $urandom_range(2);
      repeat (n_next) begin
         as_ids = 1'($urandom_range(1));
         repeat ($urandom_range(8, 16)) begin
            if (as_ids) send_req(bti_pkg::CMD_NEXT_ID, pick_id(lim), 14'($urandom),
                                 pick_mask());
            else        send_req(bti_pkg::CMD_NEXT_WORD, 20'($urandom), pick_index(lim),
                                 pick_mask());
         end
         send_req(bti_pkg::CMD_END_TAG, 20'($urandom), 14'($urandom), pick_mask());
      end
      if (q == 5) long_hold = 1'b1;
      repeat ($urandom_range(14, 24)) begin
         if ($urandom_range(1)) send_req(bti_pkg::CMD_PROBE_ID, pick_id(lim), 14'($urandom),
                                         pick_mask());
         else send_req(bti_pkg::CMD_PROBE_WORD, 20'($urandom), pick_index(lim),
                       pick_mask());
      end
   endtask

   initial begin
      logic [14:0] cfg_values [6];
      cfg_values = '{15'd1, 15'd0, 15'd40, 15'd32767, 15'd7, 15'd16384};
      sb = new();
      sb.reset_state();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bti_pkg::CMD_CLEAR;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme IDs and indexes, all-ones and zero masks, every
      // command, a zero scratch word wiping the result, then an empty range.
      send_req(bti_pkg::CMD_FIRST_ID, 20'hFFFFF, 14'h3FFF, '1);
      send_req(bti_pkg::CMD_FIRST_ID, 20'h00000, 14'h0000, '0);
      send_req(bti_pkg::CMD_FIRST_WORD, 20'h0, 14'h3FFF, '1);
      send_req(bti_pkg::CMD_FIRST_WORD, 20'h0, 14'd1, 64'hA5A5_5A5A_F0F0_0F0F);
      send_req(bti_pkg::CMD_PROBE_ID, 20'hFFFFF, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_ID, 20'h00000, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'h0, 14'h3FFF, '1);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'hFFFFF, 14'd1, '1);
      send_req(bti_pkg::CMD_NEXT_ID, 20'hFFFFF, 14'h0, '0);
      send_req(bti_pkg::CMD_NEXT_WORD, 20'h0, 14'd1, 64'hFFFF_0000_FFFF_0000);
      send_req(bti_pkg::CMD_END_TAG, 20'h0, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_ID, 20'hFFFFF, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_ID, 20'h00000, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'h0, 14'd1, '1);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'h0, 14'h3FFF, '1);
      send_req(bti_pkg::CMD_CLEAR, 20'h0, 14'h0, '0);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'h0, 14'd1, '1);
      write_words_in_use(15'd0);
      send_req(bti_pkg::CMD_FIRST_WORD, 20'h0, 14'd0, '1);
      send_req(bti_pkg::CMD_FIRST_ID, 20'h0, 14'd0, '0);
      send_req(bti_pkg::CMD_PROBE_WORD, 20'h0, 14'd0, '1);
      send_req(bti_pkg::CMD_PROBE_ID, 20'h0, 14'd0, '0);

      // Random queries: the words-in-use setting changes every third query,
      // and the idle pattern rotates with each one.
      for (int q = 0; q < 16; q++) begin
         if (q % 3 == 0) write_words_in_use(cfg_values[(q / 3) % 6]);
         case (q % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         run_query(q);
      end

      go_idle();
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
